FILE: src/assert_macros.svh
// Assertion helpers for the matcher checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define NTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nearest timestamp matcher check failed");

`endif

FILE: src/nts_pkg.sv
package nts_pkg;

  localparam int ODOM_DEPTH = 128;
  localparam int SCAN_DEPTH = 128;
  localparam int OAW        = $clog2(ODOM_DEPTH);
  localparam int SAW        = $clog2(SCAN_DEPTH);
  localparam int OCW        = $clog2(ODOM_DEPTH + 1);
  localparam int SCW        = $clog2(SCAN_DEPTH + 1);

  localparam int STAMP_W = 63;
  localparam int POS_W   = 32;
  localparam int WIN_W   = 30;
  localparam int ENTRY_W = STAMP_W + 2 * POS_W;
  localparam int TDATA_W = 128;

  localparam logic [WIN_W-1:0] WIN_RESET = 30'd50000000;

  localparam logic CMD_ODOM = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SEARCH,
    ST_EMIT,
    ST_REMOVE
  } state_t;

  typedef struct packed {
    logic odom_push;
    logic scan_push;
    logic scan_pop;
    logic search_start;
    logic search_run;
    logic emit;
    logic remove_start;
    logic remove_run;
  } ctl_cmd_t;

  typedef struct packed {
    logic odom_empty;
    logic search_done;
    logic remove_done;
    logic hit;
    logic out_free;
  } ctl_stat_t;

endpackage

FILE: src/nearest_timestamp_matcher_core.sv
// Pairs each scan timestamp with the nearest stored odometry sample. An odometry
// item is stored in the idle state, as is a scan that arrives while the odometry
// store is empty (it is only queued). Any other scan dequeues the oldest queued
// scan and reads the odometry store one entry per cycle through its single read
// port; on a match the later samples are shifted down one entry per cycle. A
// result is held back only while the previous one waits in the output register.
module nearest_timestamp_matcher_core
  import nts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,  // event_stamp, pos_x, pos_y, zero pad
  input  logic               in_tuser,  // cmd
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata, // scan_stamp, match_x, match_y, zero pad
  output logic               out_tuser, // matched
  input  logic               cfg_we,
  input  logic [WIN_W-1:0]   cfg_wdata
);

  ctl_cmd_t           cmd;
  ctl_stat_t          stat;
  logic [STAMP_W-1:0] out_stamp;
  logic [POS_W-1:0]   out_x, out_y;

  nts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nts_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_stamp    (in_tdata[STAMP_W-1:0]),
    .in_x        (in_tdata[STAMP_W +: POS_W]),
    .in_y        (in_tdata[STAMP_W + POS_W +: POS_W]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_matched (out_tuser),
    .out_stamp   (out_stamp),
    .out_x       (out_x),
    .out_y       (out_y)
  );

  assign out_tdata = {{(TDATA_W - ENTRY_W){1'b0}}, out_y, out_x, out_stamp};

endmodule

FILE: src/nts_ram.sv
module nts_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata_r
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

FILE: src/nts_ctrl.sv
module nts_ctrl
  import nts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_kind,
  output logic      in_tready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind == CMD_ODOM) begin
            cmd.odom_push = 1'b1;
          end else begin
            cmd.scan_push = 1'b1;
            if (!stat.odom_empty) begin
              state_nxt = ST_DEQ;
            end
          end
        end
      end
      ST_DEQ: begin
        cmd.scan_pop     = 1'b1;
        cmd.search_start = 1'b1;
        state_nxt        = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search_run = 1'b1;
        if (stat.search_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.hit) begin
            cmd.remove_start = 1'b1;
            state_nxt        = ST_REMOVE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REMOVE: begin
        cmd.remove_run = 1'b1;
        if (stat.remove_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: src/nts_dpath.sv
module nts_dpath
  import nts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  output ctl_stat_t          stat,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [POS_W-1:0]   in_x,
  input  logic [POS_W-1:0]   in_y,
  input  logic               cfg_we,
  input  logic [WIN_W-1:0]   cfg_wdata,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic               out_matched,
  output logic [STAMP_W-1:0] out_stamp,
  output logic [POS_W-1:0]   out_x,
  output logic [POS_W-1:0]   out_y
);

  localparam logic [OAW-1:0] OLAST = OAW'(ODOM_DEPTH - 1);
  localparam logic [SAW-1:0] SLAST = SAW'(SCAN_DEPTH - 1);
  localparam logic [OCW-1:0] OFULL = OCW'(ODOM_DEPTH);
  localparam logic [SCW-1:0] SFULL = SCW'(SCAN_DEPTH);

  logic [WIN_W-1:0] win_r;

  logic [OAW-1:0] ohead_r, otail_r;
  logic [OCW-1:0] ocount_r;
  logic [SAW-1:0] shead_r, stail_r;
  logic [SCW-1:0] scount_r;

  // odometry store
  logic               o_we, o_re;
  logic [OAW-1:0]     o_waddr, o_raddr;
  logic [ENTRY_W-1:0] o_wdata, o_rdata;

  // scan queue
  logic [STAMP_W-1:0] s_rdata;

  // search pipeline
  logic [OCW-1:0]     iss_left_r;
  logic [OAW-1:0]     iss_ptr_r, iss_k_r;
  logic               iss_first_r;
  logic               s1_v_r, s1_first_r;
  logic [OAW-1:0]     s1_ptr_r, s1_k_r;
  logic               d2_v_r, d2_first_r;
  logic [STAMP_W-1:0] d2_diff_r;
  logic [POS_W-1:0]   d2_x_r, d2_y_r;
  logic [OAW-1:0]     d2_ptr_r, d2_k_r;
  logic [STAMP_W-1:0] best_d_r;
  logic [POS_W-1:0]   best_x_r, best_y_r;
  logic [OAW-1:0]     best_ptr_r, best_k_r;

  // removal shift
  logic [OCW-1:0] rem_left_r;
  logic [OAW-1:0] rem_rp_r, rem_wp_r;
  logic           rem_pend_r;

  logic               out_tvalid_r, out_matched_r;
  logic [STAMP_W-1:0] out_stamp_r;
  logic [POS_W-1:0]   out_x_r, out_y_r;

  logic [STAMP_W-1:0] s1_t;
  logic [STAMP_W-1:0] s1_diff;
  logic               hit;
  logic               iss_go, rem_go, rem_done;

  function automatic logic [OAW-1:0] oinc(input logic [OAW-1:0] p);
    return (p == OLAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SAW-1:0] sinc(input logic [SAW-1:0] p);
    return (p == SLAST) ? '0 : p + 1'b1;
  endfunction

  assign iss_go   = cmd.search_run && (iss_left_r != '0);
  assign rem_go   = cmd.remove_run && (rem_left_r != '0);
  assign rem_done = (rem_left_r == '0) && !rem_pend_r;
  assign hit      = best_d_r < {{(STAMP_W - WIN_W){1'b0}}, win_r};

  assign s1_t    = o_rdata[STAMP_W-1:0];
  assign s1_diff = (s1_t >= s_rdata) ? (s1_t - s_rdata) : (s_rdata - s1_t);

  always_comb begin
    o_we    = 1'b0;
    o_waddr = otail_r;
    o_wdata = {in_y, in_x, in_stamp};
    if (cmd.odom_push) begin
      o_we = 1'b1;
    end else if (cmd.remove_run && rem_pend_r) begin
      o_we    = 1'b1;
      o_waddr = rem_wp_r;
      o_wdata = o_rdata;
    end
    o_re    = iss_go || rem_go;
    o_raddr = cmd.remove_run ? rem_rp_r : iss_ptr_r;
  end

  nts_ram #(.W(ENTRY_W), .D(ODOM_DEPTH)) u_odom_ram (
    .clk     (clk),
    .we      (o_we),
    .waddr   (o_waddr),
    .wdata   (o_wdata),
    .re      (o_re),
    .raddr   (o_raddr),
    .rdata_r (o_rdata)
  );

  nts_ram #(.W(STAMP_W), .D(SCAN_DEPTH)) u_scan_ram (
    .clk     (clk),
    .we      (cmd.scan_push),
    .waddr   (stail_r),
    .wdata   (in_stamp),
    .re      (cmd.scan_pop),
    .raddr   (shead_r),
    .rdata_r (s_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= WIN_RESET;
      ohead_r      <= '0;
      otail_r      <= '0;
      ocount_r     <= '0;
      shead_r      <= '0;
      stail_r      <= '0;
      scount_r     <= '0;
      iss_left_r   <= '0;
      s1_v_r       <= 1'b0;
      d2_v_r       <= 1'b0;
      rem_left_r   <= '0;
      rem_pend_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
      if (cmd.odom_push) begin
        otail_r <= oinc(otail_r);
        if (ocount_r == OFULL) begin
          ohead_r <= oinc(ohead_r);
        end else begin
          ocount_r <= ocount_r + 1'b1;
        end
      end
      if (cmd.scan_push) begin
        stail_r <= sinc(stail_r);
        if (scount_r == SFULL) begin
          shead_r <= sinc(shead_r);
        end else begin
          scount_r <= scount_r + 1'b1;
        end
      end
      if (cmd.scan_pop) begin
        shead_r  <= sinc(shead_r);
        scount_r <= scount_r - 1'b1;
      end
      if (cmd.search_start) begin
        iss_left_r <= ocount_r;
        s1_v_r     <= 1'b0;
        d2_v_r     <= 1'b0;
      end else if (cmd.search_run) begin
        if (iss_go) begin
          iss_left_r <= iss_left_r - 1'b1;
        end
        s1_v_r <= iss_go;
        d2_v_r <= s1_v_r;
      end
      if (cmd.remove_start) begin
        rem_left_r <= ocount_r - 1'b1 - {{(OCW - OAW){1'b0}}, best_k_r};
        rem_pend_r <= 1'b0;
      end else if (cmd.remove_run) begin
        if (rem_go) begin
          rem_left_r <= rem_left_r - 1'b1;
        end
        rem_pend_r <= rem_go;
        if (rem_done) begin
          otail_r  <= rem_wp_r;
          ocount_r <= ocount_r - 1'b1;
        end
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      iss_ptr_r   <= ohead_r;
      iss_k_r     <= '0;
      iss_first_r <= 1'b1;
    end else if (iss_go) begin
      iss_ptr_r   <= oinc(iss_ptr_r);
      iss_k_r     <= iss_k_r + 1'b1;
      iss_first_r <= 1'b0;
    end
    if (iss_go) begin
      s1_ptr_r   <= iss_ptr_r;
      s1_k_r     <= iss_k_r;
      s1_first_r <= iss_first_r;
    end
    if (s1_v_r) begin
      d2_diff_r  <= s1_diff;
      d2_x_r     <= o_rdata[STAMP_W +: POS_W];
      d2_y_r     <= o_rdata[STAMP_W + POS_W +: POS_W];
      d2_ptr_r   <= s1_ptr_r;
      d2_k_r     <= s1_k_r;
      d2_first_r <= s1_first_r;
    end
    if (cmd.search_run && d2_v_r && (d2_first_r || (d2_diff_r < best_d_r))) begin
      best_d_r   <= d2_diff_r;
      best_x_r   <= d2_x_r;
      best_y_r   <= d2_y_r;
      best_ptr_r <= d2_ptr_r;
      best_k_r   <= d2_k_r;
    end
    if (cmd.remove_start) begin
      rem_rp_r <= oinc(best_ptr_r);
      rem_wp_r <= best_ptr_r;
    end else if (cmd.remove_run) begin
      if (rem_go) begin
        rem_rp_r <= oinc(rem_rp_r);
      end
      if (rem_pend_r) begin
        rem_wp_r <= oinc(rem_wp_r);
      end
    end
    if (cmd.emit) begin
      out_matched_r <= hit;
      out_stamp_r   <= s_rdata;
      out_x_r       <= hit ? best_x_r : '0;
      out_y_r       <= hit ? best_y_r : '0;
    end
  end

  assign stat.odom_empty  = (ocount_r == '0);
  assign stat.search_done = (iss_left_r == '0) && !s1_v_r && !d2_v_r;
  assign stat.remove_done = rem_done;
  assign stat.hit         = hit;
  assign stat.out_free    = !out_tvalid_r || out_tready;

  assign out_tvalid  = out_tvalid_r;
  assign out_matched = out_matched_r;
  assign out_stamp   = out_stamp_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;

endmodule

FILE: src/nts_checker.sv
`include "assert_macros.svh"

module nts_checker
  import nts_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               in_tuser,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tuser
);

  `NTS_ASSERT(a_unmatched_zero, clk, rst_n, (out_tvalid && !out_tuser) |-> (out_tdata[TDATA_W-1:STAMP_W] == '0))
  `NTS_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> out_tvalid)
  `NTS_ASSERT(a_odom_one_cycle, clk, rst_n, (in_tvalid && in_tready && (in_tuser == CMD_ODOM)) |=> in_tready)
  `NTS_ASSERT(a_scan_no_instant, clk, rst_n, (in_tvalid && in_tready && (in_tuser == CMD_SCAN)) |=> !$rose(out_tvalid))

endmodule

bind nearest_timestamp_matcher_core nts_checker u_nts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
